FILE: hdl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is high.
`define A2R_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define A2R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hdl/a2r_pkg.sv
// Shared constants of the four-quadrant arctangent block.
`default_nettype none
package a2r_pkg;
   localparam int A2R_INPUT_WIDTH     = 16;
   localparam int A2R_ANGLE_FRAC_BITS = 13;

   // Ratio is unsigned Q0.16; the value 1.0 needs a seventeenth bit.
   localparam int RATIO_FRAC_BITS = 16;
   localparam int RATIO_WIDTH     = RATIO_FRAC_BITS + 1;

   // Polynomial terms are unsigned Q.24 and always stay below 2^25.
   localparam int POLY_WIDTH = 25;

   localparam logic [POLY_WIDTH-1:0] COEF_C1 = 25'd5;
   localparam logic [POLY_WIDTH-1:0] COEF_C2 = 25'd16776773;
   localparam logic [POLY_WIDTH-1:0] COEF_C3 = 25'd2473634;
   localparam logic [POLY_WIDTH-1:0] COEF_C4 = 25'd5200625;
   localparam logic [POLY_WIDTH-1:0] COEF_C5 = 25'd843924;
   localparam logic [POLY_WIDTH-1:0] COEF_C6 = 25'd2467994;
   localparam logic [POLY_WIDTH-1:0] COEF_C7 = 25'd10812313;
   localparam logic [POLY_WIDTH-1:0] ONE_Q24 = 25'd16777216;

   // Pi in unsigned Q.32.
   localparam logic [63:0] PI_Q32 = 64'd13493037705;
endpackage
`default_nettype wire

FILE: hdl/a2r_if.sv
// Valid/ready channel interfaces for the coordinate words and the angle words.
`default_nettype none
interface a2r_req_if #(parameter int INPUT_WIDTH = a2r_pkg::A2R_INPUT_WIDTH);
   logic                          valid;
   logic                          ready;
   logic signed [INPUT_WIDTH-1:0] y_value;
   logic signed [INPUT_WIDTH-1:0] x_value;

   modport source (output valid, output y_value, output x_value, input ready);
   modport sink   (input valid, input y_value, input x_value, output ready);
endinterface

interface a2r_rsp_if #(parameter int ANGLE_FRAC_BITS = a2r_pkg::A2R_ANGLE_FRAC_BITS);
   logic                              valid;
   logic                              ready;
   logic signed [ANGLE_FRAC_BITS+2:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface
`default_nettype wire

FILE: hdl/a2r_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module a2r_divider #(
   parameter int DEN_WIDTH  = 25,
   parameter int QUO_WIDTH  = 14,
   parameter int SIDE_WIDTH = 3
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          enable,
   input  wire logic                          in_valid,
   input  wire logic [DEN_WIDTH+QUO_WIDTH-1:0] dividend,
   input  wire logic [DEN_WIDTH-1:0]           divisor,
   input  wire logic [SIDE_WIDTH-1:0]          in_side,
   output logic                               out_valid,
   output logic [QUO_WIDTH-1:0]               quotient,
   output logic [SIDE_WIDTH-1:0]              out_side
);
   // The caller guarantees the quotient fits QUO_WIDTH bits, so the upper
   // dividend bits are already a partial remainder below the divisor.
   logic                  valid_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]  rem_ff   [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  low_ff   [QUO_WIDTH];
   logic [QUO_WIDTH-1:0]  quo_ff   [QUO_WIDTH];
   logic [DEN_WIDTH-1:0]  den_ff   [QUO_WIDTH];
   logic [SIDE_WIDTH-1:0] side_ff  [QUO_WIDTH];

   for (genvar k = 0; k < QUO_WIDTH; k++) begin : g_step
      logic                  valid_cur;
      logic [DEN_WIDTH-1:0]  rem_cur;
      logic [QUO_WIDTH-1:0]  low_cur;
      logic [QUO_WIDTH-1:0]  quo_cur;
      logic [DEN_WIDTH-1:0]  den_cur;
      logic [SIDE_WIDTH-1:0] side_cur;
      logic [DEN_WIDTH:0]    trial;
      logic [DEN_WIDTH:0]    diff;
      logic                  qbit;
      logic [DEN_WIDTH-1:0]  rem_in;
      logic [QUO_WIDTH-1:0]  low_in;
      logic [QUO_WIDTH-1:0]  quo_in;

      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = dividend[DEN_WIDTH+QUO_WIDTH-1:QUO_WIDTH];
         assign low_cur   = dividend[QUO_WIDTH-1:0];
         assign quo_cur   = '0;
         assign den_cur   = divisor;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[k-1];
         assign rem_cur   = rem_ff[k-1];
         assign low_cur   = low_ff[k-1];
         assign quo_cur   = quo_ff[k-1];
         assign den_cur   = den_ff[k-1];
         assign side_cur  = side_ff[k-1];
      end

      assign trial  = {rem_cur, low_cur[QUO_WIDTH-1]};
      assign diff   = trial - {1'b0, den_cur};
      assign qbit   = ~diff[DEN_WIDTH];
      assign rem_in = qbit ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      assign low_in = {low_cur[QUO_WIDTH-2:0], 1'b0};
      assign quo_in = {quo_cur[QUO_WIDTH-2:0], qbit};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= low_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_cur;
            side_ff[k] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign quotient  = quo_ff[QUO_WIDTH-1];
   assign out_side  = side_ff[QUO_WIDTH-1];
endmodule
`default_nettype wire

FILE: hdl/atan2_rational_approx.sv
// Top level of the pipelined four-quadrant arctangent, atan2(y, x).
`default_nettype none
// This block returns atan2(y_value, x_value) in radians as a signed
// Q3.ANGLE_FRAC_BITS word in [-pi, pi]. It folds the point into the first
// octant with the rounded ratio min(|x|,|y|)/max(|x|,|y|), evaluates a
// fourth-over-second order rational polynomial in that ratio, divides its
// numerator by its denominator, and unfolds the octant. When both inputs
// are zero the angle is zero; when y is zero and x is negative the angle is
// +pi. The pipeline takes one word every cycle while the result side does
// not stall, and holds no state between words. It has one register for the
// magnitude fold, 17 stages of the ratio divider, four multiplier stages,
// ANGLE_FRAC_BITS + 1 stages of the final divider and the output register.
// The whole pipeline advances together whenever the output register is empty
// or its word is being taken, so a stall on the result side holds every word
// in place and nothing is lost or repeated.
`include "assert_macros.svh"
module atan2_rational_approx #(
   parameter int INPUT_WIDTH     = a2r_pkg::A2R_INPUT_WIDTH,
   parameter int ANGLE_FRAC_BITS = a2r_pkg::A2R_ANGLE_FRAC_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   a2r_req_if.sink   req_bus,
   a2r_rsp_if.source rsp_bus
);
   localparam int W         = INPUT_WIDTH;
   localparam int F         = ANGLE_FRAC_BITS;
   localparam int AW        = F + 3;
   localparam int PW        = a2r_pkg::POLY_WIDTH;
   localparam int RW        = a2r_pkg::RATIO_WIDTH;
   localparam int RF        = a2r_pkg::RATIO_FRAC_BITS;
   localparam int AQW       = F + 1;
   localparam logic [63:0] PiWide  =
      (a2r_pkg::PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);
   localparam logic [63:0] HalfWide =
      (a2r_pkg::PI_Q32 + (64'd1 << (32 - F))) >> (33 - F);
   localparam logic signed [AW-1:0] PiF     = $signed(PiWide[AW-1:0]);
   localparam logic signed [AW-1:0] HalfPiF = $signed(HalfWide[AW-1:0]);
   localparam logic [RW-1:0]        RatioOne = RW'(1) << RF;

   // Rounded product a*r in Q.24, with r in Q0.16.
   function automatic logic [PW-1:0] mul_rnd(input logic [PW-1:0] a,
                                             input logic [RW-1:0] r);
      logic [PW+RW-1:0] prod;
      logic [PW+RW-1:0] rounded;
      prod    = {{RW{1'b0}}, a} * {{PW{1'b0}}, r};
      rounded = prod + (PW+RW)'(1 << (RF - 1));
      return rounded[PW+RF-1:RF];
   endfunction

   // The whole pipeline moves when the output register can take a word.
   logic enable;
   logic rsp_valid_ff;
   assign enable        = ~rsp_valid_ff | rsp_bus.ready;
   assign req_bus.ready = enable;

   // Fold stage: magnitudes, the larger and the smaller, and the octant flags.
   logic [W-1:0] abs_y;
   logic [W-1:0] abs_x;
   logic         swap;
   logic         fold_valid_ff;
   logic [W-1:0] fold_max_ff;
   logic [W-1:0] fold_min_ff;
   logic [3:0]   fold_flags_ff;

   assign abs_y = req_bus.y_value[W-1] ? (~req_bus.y_value + W'(1)) : req_bus.y_value;
   assign abs_x = req_bus.x_value[W-1] ? (~req_bus.x_value + W'(1)) : req_bus.x_value;
   assign swap  = abs_y > abs_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (enable) begin
         fold_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fold_max_ff   <= swap ? abs_y : abs_x;
         fold_min_ff   <= swap ? abs_x : abs_y;
         fold_flags_ff <= {(abs_x == '0) && (abs_y == '0), swap,
                           req_bus.x_value[W-1], req_bus.y_value[W-1]};
      end
   end

   // Ratio divider: ((min << 16) + max/2) / max, 17 quotient bits.
   logic [W+RW-1:0] ratio_dividend;
   logic            ratio_valid;
   logic [RW-1:0]   ratio_quo;
   logic [3:0]      ratio_flags;
   logic [RW-1:0]   ratio;

   assign ratio_dividend = {1'b0, fold_min_ff, {RF{1'b0}}}
                         + {{RW{1'b0}}, 1'b0, fold_max_ff[W-1:1]};

   a2r_divider #(
      .DEN_WIDTH  (W),
      .QUO_WIDTH  (RW),
      .SIDE_WIDTH (4)
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (fold_valid_ff),
      .dividend  (ratio_dividend),
      .divisor   (fold_max_ff),
      .in_side   (fold_flags_ff),
      .out_valid (ratio_valid),
      .quotient  (ratio_quo),
      .out_side  (ratio_flags)
   );

   // With both inputs zero the divisor is zero; the ratio is forced to zero.
   assign ratio = ratio_flags[3] ? '0 : ratio_quo;

   // Polynomial stages in Horner form, one or two multiplications per stage.
   logic          p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [RW-1:0] p1_r_ff, p2_r_ff, p3_r_ff;
   logic [2:0]    p1_flags_ff, p2_flags_ff, p3_flags_ff, p4_flags_ff;
   logic [PW-1:0] p1_t_ff, p2_t_ff, p3_t_ff, p4_num_ff;
   logic [PW-1:0] p1_d_ff, p2_den_ff, p3_den_ff, p4_den_ff;
   logic [PW-1:0] p1_t_in, p1_d_in, p2_t_in, p2_den_in, p3_t_in, p4_num_in;

   assign p1_t_in   = a2r_pkg::COEF_C4 - mul_rnd(a2r_pkg::COEF_C5, ratio);
   assign p1_d_in   = a2r_pkg::COEF_C6 + mul_rnd(a2r_pkg::COEF_C7, ratio);
   assign p2_t_in   = a2r_pkg::COEF_C3 + mul_rnd(p1_t_ff, p1_r_ff);
   assign p2_den_in = a2r_pkg::ONE_Q24 + mul_rnd(p1_d_ff, p1_r_ff);
   assign p3_t_in   = a2r_pkg::COEF_C2 + mul_rnd(p2_t_ff, p2_r_ff);
   assign p4_num_in = a2r_pkg::COEF_C1 + mul_rnd(p3_t_ff, p3_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= ratio_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_r_ff     <= ratio;
         p1_flags_ff <= ratio_flags[2:0];
         p1_t_ff     <= p1_t_in;
         p1_d_ff     <= p1_d_in;
         p2_r_ff     <= p1_r_ff;
         p2_flags_ff <= p1_flags_ff;
         p2_t_ff     <= p2_t_in;
         p2_den_ff   <= p2_den_in;
         p3_r_ff     <= p2_r_ff;
         p3_flags_ff <= p2_flags_ff;
         p3_t_ff     <= p3_t_in;
         p3_den_ff   <= p2_den_ff;
         p4_flags_ff <= p3_flags_ff;
         p4_num_ff   <= p4_num_in;
         p4_den_ff   <= p3_den_ff;
      end
   end

   // Final divider: ((num << F) + den/2) / den gives the octant angle.
   logic [PW+AQW-1:0] angle_dividend;
   logic              oct_valid;
   logic [AQW-1:0]    oct_angle;
   logic [2:0]        oct_flags;

   assign angle_dividend = {1'b0, p4_num_ff, {F{1'b0}}}
                         + {{AQW{1'b0}}, 1'b0, p4_den_ff[PW-1:1]};

   a2r_divider #(
      .DEN_WIDTH  (PW),
      .QUO_WIDTH  (AQW),
      .SIDE_WIDTH (3)
   ) u_angle_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (p4_valid_ff),
      .dividend  (angle_dividend),
      .divisor   (p4_den_ff),
      .in_side   (p4_flags_ff),
      .out_valid (oct_valid),
      .quotient  (oct_angle),
      .out_side  (oct_flags)
   );

   // Octant unfold: reflect about pi/4, then about pi/2, then mirror in x.
   logic signed [AW-1:0] unfold_a;
   logic signed [AW-1:0] unfold_b;
   logic signed [AW-1:0] unfold_c;
   logic signed [AW-1:0] angle_in;
   logic signed [AW-1:0] angle_ff;

   assign unfold_a = $signed({2'b00, oct_angle});
   assign unfold_b = oct_flags[2] ? (HalfPiF - unfold_a) : unfold_a;
   assign unfold_c = oct_flags[1] ? (PiF - unfold_b) : unfold_b;
   assign angle_in = oct_flags[0] ? -unfold_c : unfold_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= oct_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.angle = angle_ff;

   // The rounded ratio never exceeds 1.0.
   `A2R_ASSERT_IMPL(a_ratio_range, clock, reset, ratio_valid, ratio <= RatioOne)
   // The first-octant angle never exceeds pi/2 before unfolding.
   `A2R_ASSERT_IMPL(a_octant_range, clock, reset, oct_valid,
                    $signed({2'b00, oct_angle}) <= HalfPiF)
   // A delivered angle lies within [-pi, pi].
   `A2R_ASSERT_IMPL(a_angle_range, clock, reset, rsp_valid_ff,
                    (angle_ff <= PiF) && (angle_ff >= -PiF))
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the pipelined four-quadrant arctangent block.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = a2r_pkg::A2R_INPUT_WIDTH;
   localparam int FB = a2r_pkg::A2R_ANGLE_FRAC_BITS;
   localparam int AW = FB + 3;
   // PIPE_DEPTH counts the pipeline registers; the drain wait at the end allows a margin.
   localparam int PIPE_DEPTH = 24 + FB;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [IW-1:0] y_value;
      logic signed [IW-1:0] x_value;
   } coord_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   a2r_req_if #(.INPUT_WIDTH(IW)) req_bus ();
   a2r_rsp_if #(.ANGLE_FRAC_BITS(FB)) rsp_bus ();

   atan2_rational_approx #(.INPUT_WIDTH(IW), .ANGLE_FRAC_BITS(FB)) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   coord_word_type      pending_words[$];
   logic [AW-1:0]       expected_angles[$];
   int                  error_count = 0;
   int                  cycle_count = 0;
   // Set by the stimulus to make the receiver hold off for a long stretch.
   int                  long_stall_request = 0;
   int                  sink_hold = 0;
   int                  send_gap = 0;
   bit                  drain_pause = 1'b0;

   // Rounded multiply of a Q.24 term by the Q0.16 ratio.
   function automatic longint unsigned round_mul(longint unsigned a, longint unsigned r);
      return (a * r + 64'd32768) >> 16;
   endfunction

   // Predicts the angle word for one coordinate pair.
   function automatic logic [AW-1:0] predict_angle(coord_word_type w);
      longint y, x, res;
      longint unsigned ay, ax, mx, mn, r, t, num, den, a, pi_f, half_pi_f;
      y = longint'(w.y_value);
      x = longint'(w.x_value);
      ay = (y < 0) ? -y : y;
      ax = (x < 0) ? -x : x;
      mx = (ax > ay) ? ax : ay;
      mn = (ax > ay) ? ay : ax;
      r = 0;
      if (mx != 0) r = ((mn << 16) + (mx >> 1)) / mx;
      t = 64'(a2r_pkg::COEF_C4) - round_mul(64'(a2r_pkg::COEF_C5), r);
      t = 64'(a2r_pkg::COEF_C3) + round_mul(t, r);
      t = 64'(a2r_pkg::COEF_C2) + round_mul(t, r);
      num = 64'(a2r_pkg::COEF_C1) + round_mul(t, r);
      den = 64'(a2r_pkg::ONE_Q24)
          + round_mul(64'(a2r_pkg::COEF_C6) + round_mul(64'(a2r_pkg::COEF_C7), r), r);
      a = ((num << FB) + (den >> 1)) / den;
      pi_f = (a2r_pkg::PI_Q32 + (64'd1 << (31 - FB))) >> (32 - FB);
      half_pi_f = (a2r_pkg::PI_Q32 + (64'd1 << (32 - FB))) >> (33 - FB);
      res = longint'(a);
      if (ay > ax) res = longint'(half_pi_f) - res;
      if (x < 0) res = longint'(pi_f) - res;
      if (y < 0) res = -res;
      return res[AW-1:0];
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 4);
   endfunction

   // Driver: offers words from the pending queue, with random gaps. A word
   // stays on the bus until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_angles.push_back(predict_angle({req_bus.y_value, req_bus.x_value}));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() > 0 && !drain_pause) begin
               req_bus.valid <= 1'b1;
               {req_bus.y_value, req_bus.x_value} <= pending_words.pop_front();
               send_gap <= random_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted angle word with the oldest prediction
   // and drives ready with its own random stalls.
   always @(posedge clock) begin
      logic [AW-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_angles.size() == 0) begin
               $error("angle word 0x%h arrived with no prediction waiting", rsp_bus.angle);
               error_count++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_bus.angle !== want) begin
                  $error("angle: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_bus.angle));
                  error_count++;
               end
            end
         end
         if (long_stall_request > 0) begin
            sink_hold = long_stall_request;
            long_stall_request = 0;
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            sink_hold = random_gap();
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_word(input logic [IW-1:0] y, input logic [IW-1:0] x);
      coord_word_type w;
      w.y_value = y;
      w.x_value = x;
      pending_words.push_back(w);
   endtask

   // Checked at the falling edge, after the driver and the monitor have
   // settled their updates for the cycle.
   task automatic wait_for_drain();
      while (pending_words.size() > 0 || req_bus.valid || expected_angles.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      logic [IW-1:0] v, maxp, maxn;
      int sel;
      maxp = {1'b0, {(IW-1){1'b1}}};
      maxn = {1'b1, {(IW-1){1'b0}}};
      req_bus.valid = 1'b0;
      req_bus.y_value = '0;
      req_bus.x_value = '0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed words: origin, the axes, equal magnitudes in every
      // quadrant, and the most negative values.
      queue_word('0, '0);
      queue_word('0, 16'sd100);
      queue_word('0, -16'sd100);
      queue_word(16'sd100, '0);
      queue_word(-16'sd100, '0);
      queue_word(16'sd77, 16'sd77);
      queue_word(16'sd77, -16'sd77);
      queue_word(-16'sd77, 16'sd77);
      queue_word(-16'sd77, -16'sd77);
      queue_word(maxn, maxn);
      queue_word(maxn, maxp);
      queue_word(maxp, maxn);
      queue_word(maxp, maxp);
      queue_word(maxn, '0);
      queue_word('0, maxn);
      queue_word(16'sd1, maxn);
      queue_word(-16'sd1, maxn);
      queue_word(maxp, 16'sd1);
      queue_word(16'sd1, maxp);
      queue_word(-16'sd1, -16'sd1);
      queue_word(16'sd3, -16'sd7);
      wait_for_drain();

      // Hold the receiver off while the sender keeps offering words so the
      // pipeline fills and stalls its input.
      long_stall_request = 300;
      for (int i = 0; i < 100; i++) queue_word(IW'($urandom), IW'($urandom));
      wait_for_drain();

      // Random words; a few bursts pause until all results are in.
      for (int i = 0; i < 1200; i++) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin
               v = IW'($urandom);
               queue_word(v, ($urandom_range(0, 1) ? v : -v));
            end
            1: queue_word(IW'(int'($urandom_range(0, 3)) - 2), IW'($urandom));
            2: queue_word(IW'($urandom), IW'(int'($urandom_range(0, 3)) - 2));
            3: queue_word($urandom_range(0, 1) ? maxn : maxp, IW'($urandom));
            default: queue_word(IW'($urandom), IW'($urandom));
         endcase
         if (i % 400 == 399) begin
            wait_for_drain();
            drain_pause = 1'b1;
            repeat ($urandom_range(5, 50)) @(posedge clock);
            drain_pause = 1'b0;
         end
      end
      wait_for_drain();
      repeat (PIPE_DEPTH + 20) @(posedge clock);

      if (error_count == 0 && expected_angles.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/a2r_pkg.sv
hdl/a2r_if.sv
hdl/a2r_divider.sv
hdl/atan2_rational_approx.sv
tb/testbench.sv
